// File: rtl/ancp_pkg.sv
`timescale 1ns / 1ps

package ancp_pkg;

    // Sequence limits
    localparam int SEQ_BUFFER_LENGTH = 32;
    localparam int MAX_DIGITS        = 3;

    localparam int SEQ_LEN_W  = $clog2(SEQ_BUFFER_LENGTH);
    localparam int DIGIT_CNT_W = $clog2(MAX_DIGITS + 1);

    localparam int COORD_W = 10;
    localparam int TICK_W  = 16;

    localparam logic [COORD_W-1:0] ACC_LIMIT      = 10'd1023;
    localparam logic [COORD_W-1:0] COORD_MAX      = 10'd999;
    localparam logic [SEQ_LEN_W-1:0] MIN_REPORT_LEN = SEQ_LEN_W'(5);
    localparam logic [TICK_W-1:0]  TICK_MAX       = 16'hFFFF;
    localparam logic [TICK_W-1:0]  TIMEOUT_RESET  = 16'd500;

    // Characters of interest
    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_R     = 8'h52;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_BRACK = 8'h5B;
    localparam logic [7:0] CH_O     = 8'h4F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [1:0] {
        PH_BRACKET = 2'd0,
        PH_ROW     = 2'd1,
        PH_COL     = 2'd2,
        PH_OTHER   = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        KIND_NONE    = 3'd0,
        KIND_KEY     = 3'd1,
        KIND_REPORT  = 3'd2,
        KIND_OTHER   = 3'd3,
        KIND_LONG    = 3'd4,
        KIND_TIMEOUT = 3'd5
    } kind_t;

    typedef struct packed {
        logic                   in_escape;
        logic [SEQ_LEN_W-1:0]   seq_length;
        phase_t                 form_phase;
        logic [COORD_W-1:0]     row_acc;
        logic [DIGIT_CNT_W-1:0] row_cnt;
        logic [COORD_W-1:0]     col_acc;
        logic [DIGIT_CNT_W-1:0] col_cnt;
        logic [TICK_W-1:0]      elapsed;
        logic [COORD_W-1:0]     last_w;
        logic [COORD_W-1:0]     last_h;
        logic [COORD_W-1:0]     scr_cols;
        logic [COORD_W-1:0]     scr_rows;
        logic                   size_valid;
    } state_t;

    typedef struct packed {
        kind_t              event_kind;
        logic [7:0]         key_byte;
        logic [COORD_W-1:0] report_row;
        logic [COORD_W-1:0] report_col;
        logic [COORD_W-1:0] width_out;
        logic [COORD_W-1:0] height_out;
        logic               size_changed;
        logic               size_known;
    } result_t;

    localparam state_t STATE_RESET = '0;

endpackage

// File: rtl/ansi_cursor_report_parser_core.sv
`timescale 1ns / 1ps
// The result item appears on the master side in the cycle after its input item is taken.
// Throughput: one item per cycle while m_tready drains the result register; set by the combinational parser update.
// s_tready stays high while the result register is empty or being drained by m_tready.
// Reset (aresetn low, synchronous): parser state and committed size clear, result register
// empties, escape timeout returns to 500 ticks.

module ansi_cursor_report_parser_core (
    input  logic        aclk,
    input  logic        aresetn,

    // Configuration: escape_timeout_ms
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,

    // Input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tuser,   // [0] req_type (0 byte, 1 tick)

    // Result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [7:0] key_byte, [17:8] report_row, [27:18] report_col,
                                   // [37:28] width_out, [47:38] height_out,
                                   // [48] size_changed, [49] size_known, [55:50] zero
    output logic [2:0]  m_tuser    // [2:0] event_kind
);
    import ancp_pkg::*;

    // Timeout register, to be written only while idle; the block itself does not enforce this
    logic [TICK_W-1:0] timeout_reg;

    // Parser state, advanced once per accepted item
    state_t state_reg;
    state_t state_next;

    // Result register
    logic    m_valid_reg;
    result_t result_reg;
    result_t result_next;

    logic s_accept;

    // Take a new item whenever the result register is free or drains this cycle
    assign s_tready = !m_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= TIMEOUT_RESET;
        end else if (cfg_wr_en) begin
            timeout_reg <= cfg_wr_data;
        end
    end

    // All per-item work: one short pass from current state to next state and result
    ancp_step u_step (
        .cur_state  (state_reg),
        .req_type   (s_tuser),
        .rx_byte    (s_tdata),
        .timeout_ms (timeout_reg),
        .next_state (state_next),
        .result     (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= STATE_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                state_reg   <= state_next;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                // drop the delivered item
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload: load on accept, hold otherwise
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = result_reg.event_kind;
    assign m_tdata  = {6'd0,
                       result_reg.size_known,
                       result_reg.size_changed,
                       result_reg.height_out,
                       result_reg.width_out,
                       result_reg.report_col,
                       result_reg.report_row,
                       result_reg.key_byte};

    // A committed size always lies in 1..999
    a_size_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.size_valid |-> (state_reg.scr_cols != '0) && (state_reg.scr_rows != '0))
        else $error("committed size holds a zero coordinate");

    // Outside a sequence the sequence bookkeeping stays cleared
    a_idle_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        !state_reg.in_escape |-> (state_reg.seq_length == '0) && (state_reg.elapsed == '0))
        else $error("sequence state left over outside a sequence");

    // A tick item always yields an empty event
    a_tick_none: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_tuser) |=> (m_valid_reg && (result_reg.event_kind == KIND_NONE)))
        else $error("tick produced an event");

    // A size change is only ever flagged on a position report
    a_change_report: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && result_reg.size_changed) |-> (result_reg.event_kind == KIND_REPORT))
        else $error("size change without position report");

endmodule

// File: rtl/ancp_step.sv
`timescale 1ns / 1ps

module ancp_step (
    input  ancp_pkg::state_t        cur_state,
    input  logic                    req_type,
    input  logic [7:0]              rx_byte,
    input  logic [15:0]             timeout_ms,
    output ancp_pkg::state_t        next_state,
    output ancp_pkg::result_t       result
);
    import ancp_pkg::*;

    // acc * 10 + d, saturating
    function automatic logic [COORD_W-1:0] acc_push(input logic [COORD_W-1:0] acc,
                                                    input logic [3:0] d);
        logic [13:0] sum;
        sum = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {10'd0, d};
        return (sum > {4'd0, ACC_LIMIT}) ? ACC_LIMIT : sum[COORD_W-1:0];
    endfunction

    function automatic state_t clear_seq(input state_t s);
        state_t r;
        r            = s;
        r.seq_length = '0;
        r.form_phase = PH_BRACKET;
        r.row_acc    = '0;
        r.row_cnt    = '0;
        r.col_acc    = '0;
        r.col_cnt    = '0;
        r.elapsed    = '0;
        return r;
    endfunction

    logic                 is_digit;
    logic [SEQ_LEN_W-1:0] len_inc;
    logic                 grows;
    logic                 in_range;

    always_comb begin
        is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
        len_inc  = cur_state.seq_length + SEQ_LEN_W'(1);
        grows    = is_digit || (rx_byte == CH_SEMI) || (rx_byte == CH_BRACK) ||
                   ((len_inc == SEQ_LEN_W'(1)) && (rx_byte == CH_O));
        in_range = (cur_state.row_acc != '0) && (cur_state.row_acc <= COORD_MAX) &&
                   (cur_state.col_acc != '0) && (cur_state.col_acc <= COORD_MAX);

        next_state          = cur_state;
        result.event_kind   = KIND_NONE;
        result.key_byte     = '0;
        result.report_row   = '0;
        result.report_col   = '0;
        result.size_changed = 1'b0;

        if (req_type) begin
            // tick: count only inside a sequence, saturate
            if (cur_state.in_escape && (cur_state.elapsed != TICK_MAX)) begin
                next_state.elapsed = cur_state.elapsed + TICK_W'(1);
            end
        end else if (rx_byte == CH_ESC) begin
            next_state           = clear_seq(cur_state);
            next_state.in_escape = 1'b1;
        end else if (cur_state.in_escape) begin
            result.key_byte = rx_byte;
            if (cur_state.elapsed > timeout_ms) begin
                result.event_kind    = KIND_TIMEOUT;
                next_state           = clear_seq(cur_state);
                next_state.in_escape = 1'b0;
            end else if (cur_state.seq_length >= SEQ_LEN_W'(SEQ_BUFFER_LENGTH - 1)) begin
                result.event_kind    = KIND_LONG;
                next_state           = clear_seq(cur_state);
                next_state.in_escape = 1'b0;
            end else if (grows) begin
                result.key_byte       = '0;
                next_state.seq_length = len_inc;
                case (cur_state.form_phase)
                    PH_BRACKET: begin
                        next_state.form_phase =
                            ((len_inc == SEQ_LEN_W'(1)) && (rx_byte == CH_BRACK)) ?
                            PH_ROW : PH_OTHER;
                    end
                    PH_ROW: begin
                        if (is_digit) begin
                            if (cur_state.row_cnt >= DIGIT_CNT_W'(MAX_DIGITS)) begin
                                next_state.form_phase = PH_OTHER;
                            end else begin
                                next_state.row_acc = acc_push(cur_state.row_acc, rx_byte[3:0]);
                                next_state.row_cnt = cur_state.row_cnt + DIGIT_CNT_W'(1);
                            end
                        end else if (rx_byte == CH_SEMI) begin
                            next_state.form_phase = PH_COL;
                        end else begin
                            next_state.form_phase = PH_OTHER;
                        end
                    end
                    PH_COL: begin
                        if (is_digit) begin
                            if (cur_state.col_cnt >= DIGIT_CNT_W'(MAX_DIGITS)) begin
                                next_state.form_phase = PH_OTHER;
                            end else begin
                                next_state.col_acc = acc_push(cur_state.col_acc, rx_byte[3:0]);
                                next_state.col_cnt = cur_state.col_cnt + DIGIT_CNT_W'(1);
                            end
                        end else begin
                            next_state.form_phase = PH_OTHER;
                        end
                    end
                    default: begin
                    end
                endcase
            end else begin
                next_state           = clear_seq(cur_state);
                next_state.in_escape = 1'b0;
                if ((cur_state.form_phase == PH_COL) && (rx_byte == CH_R) &&
                    (len_inc >= MIN_REPORT_LEN)) begin
                    result.event_kind = KIND_REPORT;
                    result.report_row = cur_state.row_acc;
                    result.report_col = cur_state.col_acc;
                    if (in_range) begin
                        next_state.last_w = cur_state.col_acc;
                        next_state.last_h = cur_state.row_acc;
                        // same report twice running and a new size: commit
                        if ((cur_state.last_w == cur_state.col_acc) &&
                            (cur_state.last_h == cur_state.row_acc) &&
                            ((cur_state.scr_cols != cur_state.col_acc) ||
                             (cur_state.scr_rows != cur_state.row_acc))) begin
                            next_state.scr_cols   = cur_state.col_acc;
                            next_state.scr_rows   = cur_state.row_acc;
                            next_state.size_valid = 1'b1;
                            result.size_changed   = 1'b1;
                        end
                    end
                end else begin
                    result.event_kind = KIND_OTHER;
                end
            end
        end else begin
            result.event_kind = KIND_KEY;
            result.key_byte   = rx_byte;
        end

        result.width_out  = next_state.scr_cols;
        result.height_out = next_state.scr_rows;
        result.size_known = next_state.size_valid;
    end

endmodule
